// ----- src/combined_lcg_shuffled_prng_defines.svh -----
// Assertion macros used by the checker file.
`ifndef COMBINED_LCG_SHUFFLED_PRNG_DEFINES_SVH
`define COMBINED_LCG_SHUFFLED_PRNG_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define CLP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define CLP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/clp_pkg.sv -----
package clp_pkg;

    localparam int VALUE_W = 31;
    localparam int MUL_W = 16;
    localparam int FOLD_W = 8;
    localparam int PROD_W = VALUE_W + MUL_W;

    localparam int TABLE_SIZE = 32;
    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int WARM_STEPS = TABLE_SIZE + 8;
    localparam int CNT_W = $clog2(WARM_STEPS);

    localparam logic [VALUE_W-1:0] MOD_ONE = 31'd2147483563;
    localparam logic [VALUE_W-1:0] MOD_TWO = 31'd2147483399;
    localparam logic [VALUE_W-1:0] MOD_ONE_LESS = MOD_ONE - 31'd1;
    localparam logic [MUL_W-1:0] MUL_ONE = 16'd40014;
    localparam logic [MUL_W-1:0] MUL_TWO = 16'd40692;
    localparam logic [VALUE_W-1:0] SEED_TWO_RESET = 31'd123456789;

    // 2^31 is congruent to these values modulo each modulus.
    localparam logic [FOLD_W-1:0] FOLD_ONE = FOLD_W'((64'd1 << VALUE_W) - 64'(MOD_ONE));
    localparam logic [FOLD_W-1:0] FOLD_TWO = FOLD_W'((64'd1 << VALUE_W) - 64'(MOD_TWO));

    // Slot divisor and its exact reciprocal for any 31-bit dividend.
    localparam logic [63:0] SLOT_DIV = 64'd1 + 64'(MOD_ONE_LESS) / TABLE_SIZE;
    localparam int SLOT_L = $clog2(SLOT_DIV);
    localparam int SLOT_SHIFT = VALUE_W + SLOT_L;
    localparam int RECIP_W = VALUE_W + 1;
    localparam logic [RECIP_W-1:0] SLOT_RECIP =
        RECIP_W'(((64'd1 << SLOT_SHIFT) + SLOT_DIV - 64'd1) / SLOT_DIV);
    localparam int SLOT_PROD_W = VALUE_W + RECIP_W;
    localparam int QUOT_W = SLOT_PROD_W - SLOT_SHIFT;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    typedef struct packed {
        logic             seed_load;
        logic             warm_load;
        logic             warm_we;
        logic [IDX_W-1:0] warm_addr;
        logic             warm_last;
        logic             slot_read;
        logic             gen_load;
        logic             finish;
    } clp_cmd_t;

endpackage

// ----- src/clp_in_if.sv -----
interface clp_in_if;
    import clp_pkg::*;

    logic               valid;
    logic               ready;
    logic               operation;
    logic [VALUE_W-1:0] seed_value;

    modport source (output valid, output operation, output seed_value, input ready);
    modport sink (input valid, input operation, input seed_value, output ready);

endinterface

// ----- src/clp_out_if.sv -----
interface clp_out_if;
    import clp_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink (input valid, input random_value, output ready);

endinterface

// ----- src/clp_ram.sv -----
module clp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/clp_modmul.sv -----
module clp_modmul (
    input  logic                        clk,
    input  logic                        second_sel,
    input  logic [clp_pkg::VALUE_W-1:0] x,
    output logic [clp_pkg::VALUE_W-1:0] r
);
    import clp_pkg::*;

    logic [MUL_W-1:0]   mul;
    logic [FOLD_W-1:0]  fold;
    logic [VALUE_W-1:0] modulus;
    logic [PROD_W-1:0]  prod_reg;
    logic [VALUE_W:0]   sum_reg;
    logic [VALUE_W:0]   sum_next;
    logic [VALUE_W:0]   diff;

    assign mul = second_sel ? MUL_TWO : MUL_ONE;
    assign fold = second_sel ? FOLD_TWO : FOLD_ONE;
    assign modulus = second_sel ? MOD_TWO : MOD_ONE;

    // The high part of the product is folded back with 2^31 = fold (mod m).
    // The folded sum stays below twice the modulus, so one subtraction ends it.
    always_comb
    begin
        sum_next = {1'b0, prod_reg[VALUE_W-1:0]}
                 + (VALUE_W+1)'(prod_reg[PROD_W-1:VALUE_W]) * (VALUE_W+1)'(fold);
        diff = sum_reg - {1'b0, modulus};
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(x) * PROD_W'(mul);
        sum_reg <= sum_next;
    end

    assign r = (sum_reg >= {1'b0, modulus}) ? diff[VALUE_W-1:0] : sum_reg[VALUE_W-1:0];

endmodule

// ----- src/clp_datapath.sv -----
module clp_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  clp_pkg::clp_cmd_t           cmd,
    input  logic [clp_pkg::VALUE_W-1:0] seed,
    output logic [clp_pkg::VALUE_W-1:0] value
);
    import clp_pkg::*;

    logic [VALUE_W-1:0]     g1_reg, g1_next;
    logic [VALUE_W-1:0]     g2_reg, g2_next;
    logic [VALUE_W-1:0]     last_reg, last_next;
    logic [TABLE_SIZE-1:0]  valid_reg, valid_next;
    logic [QUOT_W-1:0]      slotq_reg;
    logic [IDX_W-1:0]       slot_reg;
    logic [VALUE_W-1:0]     entry_reg;
    logic [VALUE_W-1:0]     result_reg;

    logic [VALUE_W-1:0]     seed_eff;
    logic [VALUE_W-1:0]     r1, r2;
    logic [SLOT_PROD_W-1:0] slot_prod;
    logic [IDX_W-1:0]       slot_sat;
    logic [VALUE_W:0]       diff;
    logic [VALUE_W:0]       diff_wrap;
    logic [VALUE_W-1:0]     wrapped;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [VALUE_W-1:0]     ram_wdata;
    logic [VALUE_W-1:0]     ram_rdata;

    clp_modmul u_gen_one (
        .clk        (clk),
        .second_sel (1'b0),
        .x          (g1_reg),
        .r          (r1)
    );

    clp_modmul u_gen_two (
        .clk        (clk),
        .second_sel (1'b1),
        .x          (g2_reg),
        .r          (r2)
    );

    clp_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (slot_sat),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        seed_eff = (seed == '0) ? VALUE_W'(1) : seed;

        slot_prod = SLOT_PROD_W'(last_reg) * SLOT_PROD_W'(SLOT_RECIP);
        if (slotq_reg >= QUOT_W'(TABLE_SIZE))
        begin
            slot_sat = IDX_W'(TABLE_SIZE - 1);
        end
        else
        begin
            slot_sat = slotq_reg[IDX_W-1:0];
        end

        // A difference below one wraps up by the first modulus minus one.
        diff = {1'b0, entry_reg} - {1'b0, g2_reg};
        diff_wrap = diff + {1'b0, MOD_ONE_LESS};
        wrapped = (diff[VALUE_W] || (diff == '0)) ? diff_wrap[VALUE_W-1:0]
                                                  : diff[VALUE_W-1:0];

        ram_we = cmd.warm_we || cmd.finish;
        ram_waddr = cmd.finish ? slot_reg : cmd.warm_addr;
        ram_wdata = cmd.finish ? g1_reg : r1;

        g1_next = g1_reg;
        if (cmd.seed_load)
        begin
            g1_next = seed_eff;
        end
        else if (cmd.warm_load || cmd.gen_load)
        begin
            g1_next = r1;
        end

        g2_next = g2_reg;
        if (cmd.seed_load)
        begin
            g2_next = seed_eff;
        end
        else if (cmd.gen_load)
        begin
            g2_next = r2;
        end

        last_next = last_reg;
        if (cmd.warm_last)
        begin
            last_next = r1;
        end
        else if (cmd.finish)
        begin
            last_next = wrapped;
        end

        valid_next = valid_reg;
        if (ram_we)
        begin
            valid_next[ram_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_reg <= VALUE_W'(1);
            g2_reg <= SEED_TWO_RESET;
            last_reg <= '0;
            valid_reg <= '0;
        end
        else
        begin
            g1_reg <= g1_next;
            g2_reg <= g2_next;
            last_reg <= last_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slotq_reg <= slot_prod[SLOT_PROD_W-1:SLOT_SHIFT];
        if (cmd.slot_read)
        begin
            slot_reg <= slot_sat;
        end
        if (cmd.gen_load)
        begin
            // Entries never written since reset read as zero.
            entry_reg <= valid_reg[slot_reg] ? ram_rdata : '0;
        end
        if (cmd.finish)
        begin
            result_reg <= wrapped;
        end
    end

    assign value = result_reg;

endmodule

// ----- src/clp_ctrl.sv -----
module clp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              operation,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output clp_pkg::clp_cmd_t cmd
);
    import clp_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_WARM_MUL  = 3'd1;
    localparam logic [2:0] S_WARM_FOLD = 3'd2;
    localparam logic [2:0] S_WARM_LOAD = 3'd3;
    localparam logic [2:0] S_DRAW_MUL  = 3'd4;
    localparam logic [2:0] S_DRAW_READ = 3'd5;
    localparam logic [2:0] S_DRAW_STEP = 3'd6;
    localparam logic [2:0] S_DRAW_DONE = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd = '0;
        cmd.warm_addr = cnt_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                // The multipliers already run on the idle state, so a plain
                // draw skips the first pipeline step.
                if (accept)
                begin
                    if (operation == OP_RESEED)
                    begin
                        cmd.seed_load = 1'b1;
                        cnt_next = CNT_W'(WARM_STEPS - 1);
                        state_next = S_WARM_MUL;
                    end
                    else
                    begin
                        state_next = S_DRAW_READ;
                    end
                end
            end
            S_WARM_MUL:
            begin
                state_next = S_WARM_FOLD;
            end
            S_WARM_FOLD:
            begin
                state_next = S_WARM_LOAD;
            end
            S_WARM_LOAD:
            begin
                cmd.warm_load = 1'b1;
                cmd.warm_we = (cnt_reg < CNT_W'(TABLE_SIZE));
                if (cnt_reg == '0)
                begin
                    cmd.warm_last = 1'b1;
                    state_next = S_DRAW_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    state_next = S_WARM_MUL;
                end
            end
            S_DRAW_MUL:
            begin
                state_next = S_DRAW_READ;
            end
            S_DRAW_READ:
            begin
                cmd.slot_read = 1'b1;
                state_next = S_DRAW_STEP;
            end
            S_DRAW_STEP:
            begin
                cmd.gen_load = 1'b1;
                state_next = S_DRAW_DONE;
            end
            S_DRAW_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- src/combined_lcg_shuffled_prng.sv -----
// Channel   Role     Payload
// cmd       sink     operation (1 bit), seed_value (31 bits)
// result    source   random_value (31 bits)
//
// A draw steps through the READ, STEP and DONE states and registers its result in DONE;
// a new word is taken only in the idle state, after the last one is through. A reseed runs
// the TABLE_SIZE + 8 warm-up steps (two multiplier stages and the load), then the draw.
// Reset clears the table's valid bits at once; there is no clearing pass.
// A new word is taken while a result waits; its work holds in the last state
// until the output register is free.
module combined_lcg_shuffled_prng (
    input  logic      clk,
    input  logic      rst_n,
    clp_in_if.sink    cmd,
    clp_out_if.source result
);
    import clp_pkg::*;

    clp_cmd_t ctrl_cmd;

    clp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .operation (cmd.operation),
        .in_ready  (cmd.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (ctrl_cmd)
    );

    clp_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ctrl_cmd),
        .seed  (cmd.seed_value),
        .value (result.random_value)
    );

endmodule

// ----- src/clp_checker.sv -----
`include "combined_lcg_shuffled_prng_defines.svh"

module clp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cmd_valid,
    input logic                        cmd_ready,
    input logic                        result_valid,
    input logic                        result_ready,
    input logic [clp_pkg::VALUE_W-1:0] result_value
);
    import clp_pkg::*;

    `CLP_ASSERT_NXT(a_result_held, result_valid && !result_ready, result_valid, "result word dropped before it was taken")
    `CLP_ASSERT_NXT(a_value_stable, result_valid && !result_ready, $stable(result_value), "stalled result word changed")
    `CLP_ASSERT_IMP(a_value_range, result_valid, (result_value != '0) && (result_value <= MOD_ONE_LESS), "result outside its range")
    `CLP_ASSERT_NXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "command taken while a word is still in work")

endmodule

bind combined_lcg_shuffled_prng clp_checker u_clp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_value (result.random_value)
);
